[rtl/tpt_pkg.sv]
// Shared types and constants for the text position tracker.
`timescale 1ns / 1ps

package tpt_pkg;

  localparam int LINE_W     = 32;
  localparam int COL_OUT_W  = 16;
  localparam int BYTES_W    = 40;

  localparam logic [7:0]         NEWLINE_BYTE = 8'd10;
  localparam logic [LINE_W-1:0]  LINE_MAX     = '1;
  localparam logic [BYTES_W-1:0] BYTES_MAX    = '1;

  // Action codes carried on the input channel
  localparam logic ACT_CONSUME = 1'b0;
  localparam logic ACT_UNDO    = 1'b1;

  // Column update chosen in the front stage, applied in the column stage
  typedef enum logic [2:0] {
    COL_SET_ONE = 3'd0,
    COL_INC     = 3'd1,
    COL_DEC     = 3'd2,
    COL_POP     = 3'd3,
    COL_ZERO    = 3'd4
  } col_op_t;

  // One item between the front stage and the column stage
  typedef struct packed {
    col_op_t             op;
    logic                push;
    logic                fwd;
    logic [LINE_W-1:0]   line;
    logic [BYTES_W-1:0]  bytes;
    logic                overflow;
    logic                underflow;
    logic                run_done;
  } stage_t;

endpackage

[rtl/tpt_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module tpt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/tpt_col_stage.sv]
// Column register and output register stage of the text position tracker.
`timescale 1ns / 1ps

module tpt_col_stage #(
  parameter int COLUMN_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s1_valid,
  input  tpt_pkg::stage_t              s1,
  input  logic [COLUMN_WIDTH-1:0]      pop_data,
  input  logic [COLUMN_WIDTH-1:0]      fwd_data,
  output logic                         s1_move,
  output logic [COLUMN_WIDTH-1:0]      col,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tpt_pkg::LINE_W-1:0]   line_number,
  output logic [tpt_pkg::COL_OUT_W-1:0] column_number,
  output logic [tpt_pkg::BYTES_W-1:0]  byte_offset,
  output logic                         stack_overflow,
  output logic                         stack_underflow,
  output logic                         run_done
);

  import tpt_pkg::*;

  localparam logic [COLUMN_WIDTH-1:0] COL_MAX = '1;

  logic [COLUMN_WIDTH-1:0]           col_next;
  logic [COL_OUT_W+COLUMN_WIDTH-1:0] col_ext;

  // Advance the item when the output slot is free or being drained
  assign s1_move = s1_valid && (!out_valid || out_ready);

  // Apply the column update picked by the front stage
  always_comb begin
    case (s1.op)
      COL_SET_ONE: col_next = COLUMN_WIDTH'(1);
      COL_INC:     col_next = (col == COL_MAX) ? col : col + COLUMN_WIDTH'(1);
      COL_DEC:     col_next = (col == '0) ? col : col - COLUMN_WIDTH'(1);
      COL_POP:     col_next = s1.fwd ? fwd_data : pop_data;
      COL_ZERO:    col_next = '0;
      default:     col_next = col;
    endcase
  end

  assign col_ext = {{COL_OUT_W{1'b0}}, col_next};

  // Hold the running column
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= COLUMN_WIDTH'(1);
    end else if (s1_move) begin
      col <= col_next;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (s1_move) begin
      line_number     <= s1.line;
      column_number   <= col_ext[COL_OUT_W-1:0];
      byte_offset     <= s1.bytes;
      stack_overflow  <= s1.overflow;
      stack_underflow <= s1.underflow;
      run_done        <= s1.run_done;
    end
  end

endmodule

[rtl/text_position_tracker_with_undo_core.sv]
// Top level of the text position tracker with undo.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_ready): one text byte per transfer, with
//   action (consume forward or undo), byte_value and run_last.
//   Output channel (out_valid/out_ready): one result per input byte with the
//   line, column and byte offset after that byte, the overflow and underflow
//   flags of the line-length stack, and run_done echoing run_last.
//   Each result passes the stage and output registers. Throughput: one byte
//   per cycle unless out_ready stalls. Line, offset and stack fill update in
//   the front stage, the column in the column stage, from the stack RAM read
//   data on an undone newline. A pop that reads the entry being pushed in
//   the same cycle takes the written column through a forwarding register.
//   Reset: line 1, column 1, offset 0, stack empty. Stack RAM contents are
//   not cleared; only entries below the fill count are read.
//   Stall: with out_ready low one item waits in the output register and one
//   in the front stage; in_ready then drops until the output drains.

module text_position_tracker_with_undo_core #(
  parameter int STACK_DEPTH  = 64,
  parameter int COLUMN_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic [7:0]                    byte_value,
  input  logic                          run_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tpt_pkg::LINE_W-1:0]    line_number,
  output logic [tpt_pkg::COL_OUT_W-1:0] column_number,
  output logic [tpt_pkg::BYTES_W-1:0]   byte_offset,
  output logic                          stack_overflow,
  output logic                          stack_underflow,
  output logic                          run_done
);

  import tpt_pkg::*;

  localparam int AW     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int FILL_W = $clog2(STACK_DEPTH + 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(STACK_DEPTH);

  logic                    in_xfer;
  logic                    is_nl;
  logic [LINE_W-1:0]       line;
  logic [LINE_W-1:0]       line_next;
  logic [BYTES_W-1:0]      bytes;
  logic [BYTES_W-1:0]      bytes_next;
  logic [FILL_W-1:0]       fill;
  logic [FILL_W-1:0]       fill_next;
  logic [FILL_W-1:0]       fill_dec;
  logic [AW-1:0]           item_addr;
  stage_t                  item;
  logic                    s1_valid;
  stage_t                  s1;
  logic [AW-1:0]           s1_addr;
  logic [COLUMN_WIDTH-1:0] fwd_data;
  logic                    s1_move;
  logic [COLUMN_WIDTH-1:0] col;
  logic [COLUMN_WIDTH-1:0] pop_data;
  logic                    ram_we;
  logic                    ram_re;

  assign in_ready = !s1_valid || s1_move;
  assign in_xfer  = in_valid && in_ready;
  assign is_nl    = (byte_value == NEWLINE_BYTE);
  assign fill_dec = fill - FILL_W'(1);

  // Push the current column when the pushing item leaves the front stage
  assign ram_we = s1_move && s1.push;
  assign ram_re = in_xfer && (item.op == COL_POP);

  // Front stage: line, offset, stack fill and the column operation
  always_comb begin
    line_next      = line;
    bytes_next     = bytes;
    fill_next      = fill;
    item_addr      = fill[AW-1:0];
    item           = '0;
    item.run_done  = run_last;
    if (action == ACT_CONSUME) begin
      if (bytes != BYTES_MAX) bytes_next = bytes + BYTES_W'(1);
      if (is_nl) begin
        item.op = COL_SET_ONE;
        if (line != LINE_MAX) line_next = line + LINE_W'(1);
        if (fill < FILL_FULL) begin
          item.push = 1'b1;
          fill_next = fill + FILL_W'(1);
        end else begin
          item.overflow = 1'b1;
        end
      end else begin
        item.op = COL_INC;
      end
    end else begin
      if (bytes != '0) bytes_next = bytes - BYTES_W'(1);
      if (is_nl) begin
        if (line != '0) line_next = line - LINE_W'(1);
        if (fill != '0) begin
          item.op   = COL_POP;
          fill_next = fill_dec;
          item_addr = fill_dec[AW-1:0];
        end else begin
          item.op        = COL_ZERO;
          item.underflow = 1'b1;
        end
      end else begin
        item.op = COL_DEC;
      end
    end
    // Forward a column written to the entry this pop reads
    item.fwd   = ram_we && (s1_addr == item_addr);
    item.line  = line_next;
    item.bytes = bytes_next;
  end

  // Hold the front-stage counters
  always_ff @(posedge clk) begin
    if (rst) begin
      line  <= LINE_W'(1);
      bytes <= '0;
      fill  <= '0;
    end else if (in_xfer) begin
      line  <= line_next;
      bytes <= bytes_next;
      fill  <= fill_next;
    end
  end

  // Stage register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // Stage register payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1       <= item;
      s1_addr  <= item_addr;
      fwd_data <= col;
    end
  end

  tpt_ram #(
    .WIDTH (COLUMN_WIDTH),
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (col),
    .re    (ram_re),
    .raddr (item_addr),
    .rdata (pop_data)
  );

  tpt_col_stage #(
    .COLUMN_WIDTH (COLUMN_WIDTH)
  ) u_col (
    .clk             (clk),
    .rst             (rst),
    .s1_valid        (s1_valid),
    .s1              (s1),
    .pop_data        (pop_data),
    .fwd_data        (fwd_data),
    .s1_move         (s1_move),
    .col             (col),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .line_number     (line_number),
    .column_number   (column_number),
    .byte_offset     (byte_offset),
    .stack_overflow  (stack_overflow),
    .stack_underflow (stack_underflow),
    .run_done        (run_done)
  );

`ifndef ASSERT_OFF
  // Fill count never passes the stack depth
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_FULL)
    else $error("stack fill above depth");

  // A stalled front-stage item is kept
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid)
    else $error("front-stage item lost while stalled");

  // Overflow is flagged only when the stack was full
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    in_xfer && fill != FILL_FULL |=> !s1.overflow)
    else $error("overflow flagged with room on the stack");

  // A pop never happens on an empty stack
  a_pop_fill: assert property (@(posedge clk) disable iff (rst)
    ram_re |-> fill != '0)
    else $error("stack read with fill zero");
`endif

endmodule
